### rtl/cpr_pkg.sv
// Shared types and constants for the clock page replacement block.
// No dependencies; every module in rtl/ imports this package.
package cpr_pkg;

   // Field widths of the item, result and configuration ports.
   localparam int PAGE_W      = 32;
   localparam int SLOT_W      = 6;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int SIU_W       = 7;

   // Register indexes on the configuration port (address bit 2).
   typedef enum logic {
      REG_SLOTS_IN_USE  = 1'b0,
      REG_NEW_REF_START = 1'b1
   } cpr_reg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture the item's page
      logic cmp;         // register the associative compare
      logic hit_done;    // finish a hit
      logic sweep_init;  // load the sweep pointer from the hand
      logic sweep_step;  // clear the reference bit and advance
      logic install;     // install the page and report the miss
   } cpr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit;         // registered compare found the page
      logic victim;      // the slot under the sweep pointer can be replaced
   } cpr_sts_type;

endpackage

### rtl/cpr_csr.sv
// Configuration registers of the clock page replacement block on an APB-style port.
// Depends on cpr_pkg.
module cpr_csr #(
   parameter int SLOTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [cpr_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [cpr_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [cpr_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output logic [$clog2(SLOTS+1)-1:0]      eff_cnt,
   output logic                            new_ref,
   output logic                            cnt_wr
);
   import cpr_pkg::*;

   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int CW    = (CNT_W > SIU_W) ? CNT_W : SIU_W;
   localparam logic [SIU_W-1:0] SIU_RESET = SIU_W'((SLOTS > 127) ? 127 : SLOTS);

   logic [SIU_W-1:0] siu_ff, siu_in;
   logic             nrs_ff, nrs_in;
   logic             cnt_wr_ff, cnt_wr_in;
   logic             wr;
   cpr_reg_type      idx;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign idx    = cpr_reg_type'(paddr[2]);

   // Register writes.
   always_comb begin
      siu_in    = siu_ff;
      nrs_in    = nrs_ff;
      cnt_wr_in = 1'b0;
      if (wr) begin
         case (idx)
            REG_SLOTS_IN_USE: begin
               siu_in    = pwdata[SIU_W-1:0];
               cnt_wr_in = 1'b1;
            end
            REG_NEW_REF_START: begin
               nrs_in = pwdata[0];
            end
            default: begin
               siu_in = siu_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         siu_ff    <= SIU_RESET;
         nrs_ff    <= 1'b1;
         cnt_wr_ff <= 1'b0;
      end else begin
         siu_ff    <= siu_in;
         nrs_ff    <= nrs_in;
         cnt_wr_ff <= cnt_wr_in;
      end
   end

   // Read back.
   always_comb begin
      case (idx)
         REG_SLOTS_IN_USE:  prdata = CSR_DATA_W'(siu_ff);
         REG_NEW_REF_START: prdata = CSR_DATA_W'(nrs_ff);
         default:           prdata = '0;
      endcase
   end

   // A count of zero acts as one; a count above the slot total acts as the total.
   always_comb begin
      if (siu_ff == '0) begin
         eff_cnt = CNT_W'(1);
      end else if (CW'(siu_ff) > CW'(SLOTS)) begin
         eff_cnt = CNT_W'(SLOTS);
      end else begin
         eff_cnt = CNT_W'(siu_ff);
      end
   end

   assign new_ref = nrs_ff;
   assign cnt_wr  = cnt_wr_ff;

endmodule

### rtl/cpr_ctrl.sv
// Controller state machine of the clock page replacement block.
// Depends on cpr_pkg; drives the commands of cpr_dp.
module cpr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output cpr_pkg::cpr_cmd_type cmd,
   input  cpr_pkg::cpr_sts_type sts
);
   import cpr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_ENC,
      ST_SWEEP,
      ST_INSTALL
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start && !busy_ff) begin
               cmd.load = 1'b1;
               state_in = ST_CMP;
               busy_in  = 1'b1;
            end
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = ST_ENC;
         end
         ST_ENC: begin
            if (sts.hit) begin
               cmd.hit_done = 1'b1;
               state_in     = ST_IDLE;
               busy_in      = 1'b0;
            end else begin
               cmd.sweep_init = 1'b1;
               state_in       = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            // The memory read of the victim's page is issued in this cycle.
            if (sts.victim) begin
               state_in = ST_INSTALL;
            end else begin
               cmd.sweep_step = 1'b1;
            end
         end
         ST_INSTALL: begin
            cmd.install = 1'b1;
            state_in    = ST_IDLE;
            busy_in     = 1'b0;
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   // State and registered busy.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

### rtl/cpr_dp.sv
// Datapath of the clock page replacement block: page compare rows, page memory,
// valid and reference bits, clock hand and result registers. Depends on cpr_pkg.
module cpr_dp #(
   parameter int SLOTS     = 64,
   parameter int PAGE_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [cpr_pkg::PAGE_W-1:0]  req_page,
   input  cpr_pkg::cpr_cmd_type        cmd,
   output cpr_pkg::cpr_sts_type        sts,
   input  logic [$clog2(SLOTS+1)-1:0]  eff_cnt,
   input  logic                        new_ref,
   input  logic                        cnt_wr,
   output logic                        rsp_strobe,
   output logic                        rsp_hit,
   output logic [cpr_pkg::SLOT_W-1:0]  rsp_slot,
   output logic                        rsp_evicted_valid,
   output logic [cpr_pkg::PAGE_W-1:0]  rsp_evicted_page
);
   import cpr_pkg::*;

   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [PAGE_BITS-1:0] page_ff;
   logic [PAGE_BITS-1:0] cam_ff [SLOTS];
   logic [PAGE_BITS-1:0] mem [SLOTS];
   logic [PAGE_BITS-1:0] rd_ff;
   logic [SLOTS-1:0]     valid_ff;
   logic [SLOTS-1:0]     ref_ff;
   logic [SLOTS-1:0]     match;
   logic [SLOTS-1:0]     match_ff;
   logic                 hit_ff;
   logic [IDX_W-1:0]     hand_ff;
   logic [IDX_W-1:0]     h_ff;
   logic [IDX_W-1:0]     h_next;
   logic [IDX_W-1:0]     hand_start;
   logic [IDX_W-1:0]     hit_idx;
   logic                 strobe_ff;
   logic                 hit_out_ff;
   logic [SLOT_W-1:0]    slot_out_ff;
   logic                 ev_valid_ff;
   logic [PAGE_W-1:0]    ev_page_ff;

   // Associative compare against every valid row.
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match[i] = valid_ff[i] && (cam_ff[i] == page_ff);
      end
   end

   // Slot of the hit; at most one valid row holds a given page.
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         hit_idx = hit_idx | (match_ff[i] ? IDX_W'(i) : '0);
      end
   end

   // Hand arithmetic wraps at the effective slot count.
   assign h_next     = ((CNT_W'(h_ff) + CNT_W'(1)) >= eff_cnt) ? '0 : h_ff + IDX_W'(1);
   assign hand_start = (CNT_W'(hand_ff) >= eff_cnt) ? '0 : hand_ff;

   assign sts.hit    = hit_ff;
   assign sts.victim = !(valid_ff[h_ff] && ref_ff[h_ff]);

   // Item page, compare rows and sweep pointer.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff <= PAGE_BITS'(req_page);
      end
      if (cmd.install) begin
         cam_ff[h_ff] <= page_ff;
      end
      if (cmd.cmp) begin
         match_ff <= match;
         hit_ff   <= |match;
      end
      if (cmd.sweep_init) begin
         h_ff <= hand_start;
      end else if (cmd.sweep_step) begin
         h_ff <= h_next;
      end
   end

   // Page memory; its registered read gives the evicted page.
   always_ff @(posedge clock) begin
      if (cmd.install) begin
         mem[h_ff] <= page_ff;
      end
      rd_ff <= mem[h_ff];
   end

   // Valid bits, reference bits, hand and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         ref_ff    <= '0;
         hand_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         if (cnt_wr) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (CNT_W'(i) >= eff_cnt) begin
                  valid_ff[i] <= 1'b0;
                  ref_ff[i]   <= 1'b0;
               end
            end
            if (CNT_W'(hand_ff) >= eff_cnt) begin
               hand_ff <= '0;
            end
         end
         if (cmd.hit_done) begin
            ref_ff <= ref_ff | match_ff;
         end
         if (cmd.sweep_step) begin
            ref_ff[h_ff] <= 1'b0;
         end
         if (cmd.install) begin
            valid_ff[h_ff] <= 1'b1;
            ref_ff[h_ff]   <= new_ref;
            hand_ff        <= h_next;
         end
         strobe_ff <= cmd.hit_done || cmd.install;
      end
   end

   // Result registers.
   always_ff @(posedge clock) begin
      if (cmd.hit_done) begin
         hit_out_ff  <= 1'b1;
         slot_out_ff <= SLOT_W'(hit_idx);
         ev_valid_ff <= 1'b0;
         ev_page_ff  <= '0;
      end else if (cmd.install) begin
         hit_out_ff  <= 1'b0;
         slot_out_ff <= SLOT_W'(h_ff);
         ev_valid_ff <= valid_ff[h_ff];
         ev_page_ff  <= valid_ff[h_ff] ? PAGE_W'(rd_ff) : '0;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_hit           = hit_out_ff;
   assign rsp_slot          = slot_out_ff;
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_page  = ev_page_ff;

endmodule

### rtl/clock_page_replacement.sv
// Top level of the clock (second chance) page replacement block.
// Depends on cpr_pkg, cpr_csr, cpr_ctrl and cpr_dp.
//
//   Channel     Handshake                           Payload
//   ---------   ---------------------------------   -------------------------------------
//   request     start & !busy                       req_page
//   response    rsp_strobe, one cycle, no stall     rsp_hit, rsp_slot, rsp_evicted_valid,
//                                                   rsp_evicted_page
//   config      psel & penable & pwrite (pready=1)  paddr, pwdata, prdata
//
// A hit passes from acceptance to rsp_strobe through page capture, the registered
// associative compare over all slots, and the result register.
// On a miss the sweep then passes each slot with a set reference bit, clearing it,
// until it reaches a victim (it passes at most the slot count); the sweep checks one
// slot per cycle, and the page memory read of the victim is registered before install.
// busy falls in the cycle rsp_strobe is shown, so the next item can be taken then.
// Reset is synchronous; valid and reference bits clear at once.
module clock_page_replacement #(
   parameter int SLOTS     = 64,
   parameter int PAGE_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [cpr_pkg::PAGE_W-1:0]      req_page,
   output logic                            rsp_strobe,
   output logic                            rsp_hit,
   output logic [cpr_pkg::SLOT_W-1:0]      rsp_slot,
   output logic                            rsp_evicted_valid,
   output logic [cpr_pkg::PAGE_W-1:0]      rsp_evicted_page,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [cpr_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [cpr_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [cpr_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import cpr_pkg::*;

   localparam int CNT_W = $clog2(SLOTS + 1);

   cpr_cmd_type      cmd;
   cpr_sts_type      sts;
   logic [CNT_W-1:0] eff_cnt;
   logic             new_ref;
   logic             cnt_wr;

   // Configuration registers.
   cpr_csr #(
      .SLOTS (SLOTS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .eff_cnt (eff_cnt),
      .new_ref (new_ref),
      .cnt_wr  (cnt_wr)
   );

   // Sequencer.
   cpr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   // Slot store and result registers.
   cpr_dp #(
      .SLOTS     (SLOTS),
      .PAGE_BITS (PAGE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_page          (req_page),
      .cmd               (cmd),
      .sts               (sts),
      .eff_cnt           (eff_cnt),
      .new_ref           (new_ref),
      .cnt_wr            (cnt_wr),
      .rsp_strobe        (rsp_strobe),
      .rsp_hit           (rsp_hit),
      .rsp_slot          (rsp_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page)
   );

endmodule

### rtl/cpr_checker.sv
// Port-level checks of the clock page replacement block, bound to its top level.
// Depends on cpr_pkg and clock_page_replacement.
module cpr_props (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_strobe,
   input logic                        rsp_hit,
   input logic                        rsp_evicted_valid,
   input logic [cpr_pkg::PAGE_W-1:0]  rsp_evicted_page
);
   import cpr_pkg::*;

   // An accepted item keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // The block leaves busy exactly when its result is shown.
   a_fall_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy fell without a result");

   // A result is never shown while an item is still at work.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // A hit never reports an eviction.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_hit |-> !rsp_evicted_valid)
      else $error("hit reported an eviction");

   // Without an eviction the evicted page reads zero.
   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_evicted_valid |-> rsp_evicted_page == '0)
      else $error("evicted page nonzero without eviction");

endmodule

bind clock_page_replacement cpr_props u_cpr_props (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_hit           (rsp_hit),
   .rsp_evicted_valid (rsp_evicted_valid),
   .rsp_evicted_page  (rsp_evicted_page)
);
